@@ rtl/cvt_pkg.sv @@
// cvt_pkg: shared types and constants for the clock vote table
// opcodes, status codes, channel words and the controller/datapath command and status
// no dependencies
package cvt_pkg;

	localparam int TABLE_DEPTH_DEF = 16;

	localparam int CPU_W = 9;
	localparam int BUS_W = 8;
	localparam int ID_W  = 4;
	localparam int OP_W  = 2;
	localparam int ST_W  = 2;

	localparam logic [CPU_W-1:0] CPU_CAP = 9'd333;
	localparam logic [BUS_W-1:0] BUS_CAP = 8'd166;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_CPU = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_BUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOT_CPU   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOT_BUS   = 2'd3;

	typedef enum logic [OP_W-1:0] {
		OP_ENTER     = 2'd0,
		OP_LEAVE     = 2'd1,
		OP_ENTER_HOT = 2'd2,
		OP_RECOMPUTE = 2'd3
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// what a table scan does with each entry it reads
	typedef enum logic [1:0] {
		PASS_TAGS  = 2'd0,
		PASS_LEAVE = 2'd1,
		PASS_BEST  = 2'd2
	} pass_t;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [CPU_W-1:0] cpu_request;
		logic [BUS_W-1:0] bus_request;
		logic [ID_W-1:0]  leave_id;
	} in_word_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [ID_W-1:0]  assigned_id;
		logic [CPU_W-1:0] cpu_clock;
		logic [BUS_W-1:0] bus_clock;
		logic             clock_change;
	} out_word_t;

	typedef struct packed {
		logic  load;
		logic  scan_start;
		pass_t pass;
		logic  search;
		logic  append;
		logic  shrink;
		logic  post;
		logic  refuse;
	} cmd_t;

	typedef struct packed {
		logic op_enter;
		logic op_leave;
		logic full;
		logic scan_done;
		logic search_hit;
	} sts_t;

endpackage

@@ rtl/cvt_chan_if.sv @@
// cvt_chan_if: valid/ready channel carrying one word of a given type
// word type comes from cvt_pkg at the instantiation
interface cvt_chan_if #(parameter type word_t = logic);

	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

@@ rtl/cvt_ram.sv @@
// cvt_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module cvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/cvt_dpath.sv @@
// cvt_dpath: table memory, scan pointer, id bitmap, winner registers and result word
// depends on cvt_pkg and cvt_ram; driven by cvt_ctrl through cmd_t / sts_t
module cvt_dpath #(
	parameter int TABLE_DEPTH = cvt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cvt_pkg::cmd_t                   cmd,
	output cvt_pkg::sts_t                   sts,
	input  cvt_pkg::in_word_t               in_word,
	output cvt_pkg::out_word_t              out_word,
	input  logic                            cfg_we,
	input  logic [cvt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cvt_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int TAG_W  = IDX_W;
	localparam int CPU_W  = cvt_pkg::CPU_W;
	localparam int BUS_W  = cvt_pkg::BUS_W;
	localparam int ID_W   = cvt_pkg::ID_W;
	localparam int SUM_W  = CPU_W + 1;
	localparam int WORD_W = TAG_W + CPU_W + BUS_W;
	localparam int CMP_W  = (TAG_W > ID_W) ? TAG_W : ID_W;

	// configuration
	logic [CPU_W-1:0] floor_cpu_q, hot_cpu_q;
	logic [BUS_W-1:0] floor_bus_q, hot_bus_q;

	// operation being worked on
	cvt_pkg::opcode_t op_q;
	logic [CPU_W-1:0] cpu_q;
	logic [BUS_W-1:0] bus_q;
	logic [ID_W-1:0]  lid_q;

	// table control
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic             busy_q;
	logic             rd_valid_s1;
	logic [CNT_W-1:0] rd_idx_s1;
	logic             found_q;
	logic [TABLE_DEPTH-1:0] used_q;
	logic [IDX_W-1:0] srch_q;

	// winner and last set pair
	logic [SUM_W-1:0] best_sum_q;
	logic [CPU_W-1:0] best_cpu_q, last_cpu_q;
	logic [BUS_W-1:0] best_bus_q, last_bus_q;

	cvt_pkg::out_word_t out_q;

	// memory ports
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic [TAG_W-1:0]  rd_tag;
	logic [CPU_W-1:0]  rd_cpu;
	logic [BUS_W-1:0]  rd_bus;
	logic [SUM_W-1:0]  rd_sum;
	logic              rd_match;
	logic              issue;
	logic [CNT_W-1:0]  prev_idx;
	logic              leave_move;

	logic [CPU_W-1:0]  cpu_floored, cpu_final;
	logic [BUS_W-1:0]  bus_floored, bus_final;
	logic              pair_change;
	cvt_pkg::status_t  status_final;

	cvt_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_tag   = ram_rdata[WORD_W-1 -: TAG_W];
	assign rd_cpu   = ram_rdata[BUS_W +: CPU_W];
	assign rd_bus   = ram_rdata[BUS_W-1:0];
	assign rd_sum   = SUM_W'(rd_cpu) + SUM_W'(rd_bus);
	assign rd_match = (CMP_W'(rd_tag) == CMP_W'(lid_q));

	assign issue     = busy_q && !cmd.scan_start && (rd_ptr_q < count_q);
	assign ram_raddr = rd_ptr_q[IDX_W-1:0];
	assign prev_idx  = rd_idx_s1 - CNT_W'(1);

	// entries behind the removed one move down by one slot
	assign leave_move = rd_valid_s1 && (cmd.pass == cvt_pkg::PASS_LEAVE) && found_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = {srch_q, cpu_q, bus_q};
		if (cmd.append) begin
			ram_we = 1'b1;
		end else if (leave_move) begin
			ram_we    = 1'b1;
			ram_waddr = prev_idx[IDX_W-1:0];
			ram_wdata = ram_rdata;
		end
	end

	// floor, then cap
	always_comb begin
		cpu_floored = (best_cpu_q < floor_cpu_q) ? floor_cpu_q : best_cpu_q;
		cpu_final   = (cpu_floored > cvt_pkg::CPU_CAP) ? cvt_pkg::CPU_CAP : cpu_floored;
		bus_floored = (best_bus_q < floor_bus_q) ? floor_bus_q : best_bus_q;
		bus_final   = (bus_floored > cvt_pkg::BUS_CAP) ? cvt_pkg::BUS_CAP : bus_floored;
		pair_change = (cpu_final != last_cpu_q) || (bus_final != last_bus_q);
		if (cmd.refuse) begin
			status_final = cvt_pkg::ST_FULL;
		end else if ((op_q == cvt_pkg::OP_LEAVE) && !found_q) begin
			status_final = cvt_pkg::ST_NOT_FOUND;
		end else begin
			status_final = cvt_pkg::ST_OK;
		end
	end

	always_comb begin
		sts.op_enter   = (op_q == cvt_pkg::OP_ENTER) || (op_q == cvt_pkg::OP_ENTER_HOT);
		sts.op_leave   = (op_q == cvt_pkg::OP_LEAVE);
		sts.full       = (count_q == CNT_W'(TABLE_DEPTH));
		sts.scan_done  = !busy_q && !rd_valid_s1 && !cmd.scan_start;
		sts.search_hit = !used_q[srch_q];
	end

	assign out_word = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_cpu_q <= '0;
			floor_bus_q <= '0;
			hot_cpu_q   <= '0;
			hot_bus_q   <= '0;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			busy_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			used_q      <= '0;
			srch_q      <= '0;
			last_cpu_q  <= '0;
			last_bus_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cvt_pkg::CFG_FLOOR_CPU: floor_cpu_q <= cfg_data;
					cvt_pkg::CFG_FLOOR_BUS: floor_bus_q <= cfg_data[BUS_W-1:0];
					cvt_pkg::CFG_HOT_CPU:   hot_cpu_q   <= cfg_data;
					cvt_pkg::CFG_HOT_BUS:   hot_bus_q   <= cfg_data[BUS_W-1:0];
				endcase
			end

			if (cmd.load) begin
				found_q <= 1'b0;
				used_q  <= '0;
				srch_q  <= '0;
			end

			// scan sequencer: one read a cycle, data back in the cycle after the read
			if (cmd.scan_start) begin
				rd_ptr_q <= '0;
				busy_q   <= 1'b1;
			end else if (busy_q) begin
				if (issue) begin
					rd_ptr_q <= rd_ptr_q + CNT_W'(1);
				end else begin
					busy_q <= 1'b0;
				end
			end
			rd_valid_s1 <= issue;

			if (rd_valid_s1) begin
				unique case (cmd.pass)
					cvt_pkg::PASS_TAGS: used_q[rd_tag] <= 1'b1;
					cvt_pkg::PASS_LEAVE: begin
						if (!found_q && rd_match) begin
							found_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end

			if (cmd.search && used_q[srch_q]) begin
				srch_q <= srch_q + IDX_W'(1);
			end

			if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.shrink && found_q) begin
				count_q <= count_q - CNT_W'(1);
			end

			if (cmd.post && !cmd.refuse) begin
				last_cpu_q <= cpu_final;
				last_bus_q <= bus_final;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			rd_idx_s1 <= rd_idx_s1 + CNT_W'(1);
		end else begin
			rd_idx_s1 <= rd_ptr_q;
		end

		if (cmd.load) begin
			op_q  <= cvt_pkg::opcode_t'(in_word.opcode);
			lid_q <= in_word.leave_id;
			if (cvt_pkg::opcode_t'(in_word.opcode) == cvt_pkg::OP_ENTER_HOT) begin
				cpu_q <= hot_cpu_q;
				bus_q <= hot_bus_q;
			end else begin
				cpu_q <= in_word.cpu_request;
				bus_q <= in_word.bus_request;
			end
			best_sum_q <= '0;
			best_cpu_q <= '0;
			best_bus_q <= '0;
		end else if (rd_valid_s1 && (cmd.pass == cvt_pkg::PASS_BEST) && (rd_sum > best_sum_q)) begin
			// strict compare keeps the earliest of equal sums
			best_sum_q <= rd_sum;
			best_cpu_q <= rd_cpu;
			best_bus_q <= rd_bus;
		end

		if (cmd.post) begin
			out_q.status <= status_final;
			if (sts.op_enter && !cmd.refuse) begin
				out_q.assigned_id <= ID_W'(srch_q);
			end else begin
				out_q.assigned_id <= '0;
			end
			if (cmd.refuse) begin
				out_q.cpu_clock    <= last_cpu_q;
				out_q.bus_clock    <= last_bus_q;
				out_q.clock_change <= 1'b0;
			end else begin
				out_q.cpu_clock    <= cpu_final;
				out_q.bus_clock    <= bus_final;
				out_q.clock_change <= pair_change;
			end
		end
	end

endmodule

@@ rtl/cvt_ctrl.sv @@
// cvt_ctrl: sequencer for one table operation, load, scans, id search, append or shrink, post
// depends on cvt_pkg; commands cvt_dpath through cmd_t and reads sts_t
module cvt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output cvt_pkg::cmd_t cmd,
	input  cvt_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_DECODE,
		S_SCAN,
		S_SEARCH,
		S_APPEND,
		S_SHRINK,
		S_POST,
		S_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	cvt_pkg::cmd_t cmd_q;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	// the input word is only held up to its accepting edge, so load follows the handshake
	always_comb begin
		cmd      = cmd_q;
		cmd.load = in_valid && in_ready_q;
	end

	// other commands are registered with the move into the state that uses them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
			cmd_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			cmd_q.scan_start <= 1'b0;
			cmd_q.append     <= 1'b0;
			cmd_q.shrink     <= 1'b0;
			cmd_q.post       <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q   <= 1'b0;
						cmd_q.refuse <= 1'b0;
						state_q      <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (sts.op_enter && sts.full) begin
						cmd_q.refuse <= 1'b1;
						state_q      <= S_POST;
					end else begin
						cmd_q.scan_start <= 1'b1;
						if (sts.op_enter) begin
							cmd_q.pass <= cvt_pkg::PASS_TAGS;
						end else if (sts.op_leave) begin
							cmd_q.pass <= cvt_pkg::PASS_LEAVE;
						end else begin
							cmd_q.pass <= cvt_pkg::PASS_BEST;
						end
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.scan_done) begin
						unique case (cmd_q.pass)
							cvt_pkg::PASS_TAGS: begin
								cmd_q.search <= 1'b1;
								state_q      <= S_SEARCH;
							end
							cvt_pkg::PASS_LEAVE: begin
								cmd_q.shrink <= 1'b1;
								state_q      <= S_SHRINK;
							end
							default: begin
								state_q <= S_POST;
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (sts.search_hit) begin
						cmd_q.search <= 1'b0;
						cmd_q.append <= 1'b1;
						state_q      <= S_APPEND;
					end
				end
				S_APPEND, S_SHRINK: begin
					cmd_q.scan_start <= 1'b1;
					cmd_q.pass       <= cvt_pkg::PASS_BEST;
					state_q          <= S_SCAN;
				end
				S_POST: begin
					// wait for the output slot to be free
					if (!out_valid_q || out_ready) begin
						cmd_q.post <= 1'b1;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					in_ready_q  <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/clock_vote_table_core.sv @@
// clock_vote_table_core: ordered table of cpu/bus clock requests with winner selection
// a result held at the output stalls the next operation in the post state
// one word at a time, next word can be taken from the cycle the result is first offered; scans read one entry a cycle
// reset empties the table and clears the last pair and the control registers at once, no sweep
// depends on cvt_pkg, cvt_chan_if, cvt_ctrl, cvt_dpath
module clock_vote_table_core #(
	parameter int TABLE_DEPTH = cvt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	cvt_chan_if.sink                        in_ch,
	cvt_chan_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [cvt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cvt_pkg::CFG_DATA_W-1:0]  cfg_data
);

	cvt_pkg::cmd_t      cmd;
	cvt_pkg::sts_t      sts;
	cvt_pkg::out_word_t out_word;

	cvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	cvt_dpath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_word   (in_ch.data),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	assign out_ch.data = out_word;

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for clock_vote_table_core, runs enter/leave/recompute traffic
// and compares every result word with a local model of the vote table
// depends on cvt_pkg, cvt_chan_if and the core rtl
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = cvt_pkg::TABLE_DEPTH_DEF;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [cvt_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cvt_pkg::CFG_DATA_W-1:0] cfg_data;

	cvt_chan_if #(.word_t(cvt_pkg::in_word_t))  in_ch ();
	cvt_chan_if #(.word_t(cvt_pkg::out_word_t)) out_ch ();

	clock_vote_table_core #(.TABLE_DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model of the table, updated on every accepted word
	logic [cvt_pkg::CPU_W-1:0] vote_cpu [DEPTH];
	logic [cvt_pkg::BUS_W-1:0] vote_bus [DEPTH];
	int                        vote_tag [DEPTH];
	int                        vote_count;
	logic [cvt_pkg::CPU_W-1:0] last_cpu;
	logic [cvt_pkg::BUS_W-1:0] last_bus;
	logic [cvt_pkg::CPU_W-1:0] floor_cpu_r;
	logic [cvt_pkg::BUS_W-1:0] floor_bus_r;
	logic [cvt_pkg::CPU_W-1:0] hot_cpu_r;
	logic [cvt_pkg::BUS_W-1:0] hot_bus_r;

	cvt_pkg::in_word_t  op_pending_q [$];
	cvt_pkg::out_word_t winner_due_q [$];

	int pushed_cnt;
	int taken_cnt;
	int rx_words;
	int err_count;
	int quiet_cycles;

	// id bookkeeping at generation time, used to aim leaves at live ids and to switch fill/drain
	logic [15:0] gen_live;
	int          gen_count;
	bit          gen_filling;

	bit calm;
	assign calm = (rx_words >= 300) && (rx_words < 380);

	function automatic cvt_pkg::out_word_t predict_vote(cvt_pkg::in_word_t w);
		cvt_pkg::out_word_t        r;
		logic [cvt_pkg::CPU_W-1:0] c;
		logic [cvt_pkg::BUS_W-1:0] b;
		int                        id;
		int                        k;
		int                        s;
		int                        best;
		int                        best_sum;
		bit                        hit;
		r = '0;
		c = w.cpu_request;
		b = w.bus_request;
		case (w.opcode)
			cvt_pkg::OP_ENTER, cvt_pkg::OP_ENTER_HOT: begin
				if (vote_count >= DEPTH) begin
					r.status    = cvt_pkg::ST_FULL;
					r.cpu_clock = last_cpu;
					r.bus_clock = last_bus;
					return r;
				end
				if (w.opcode == cvt_pkg::OP_ENTER_HOT) begin
					c = hot_cpu_r;
					b = hot_bus_r;
				end
				id = 0;
				hit = 1'b1;
				while (hit) begin
					hit = 1'b0;
					for (k = 0; k < vote_count; k++)
						if (vote_tag[k] == id)
							hit = 1'b1;
					if (hit)
						id++;
				end
				vote_cpu[vote_count] = c;
				vote_bus[vote_count] = b;
				vote_tag[vote_count] = id;
				vote_count++;
				r.assigned_id = id[cvt_pkg::ID_W-1:0];
			end
			cvt_pkg::OP_LEAVE: begin
				hit = 1'b0;
				for (k = 0; k < vote_count; k++) begin
					if (!hit && vote_tag[k] == int'(w.leave_id))
						hit = 1'b1;
					// compact while keeping order
					if (hit && k + 1 < vote_count) begin
						vote_cpu[k] = vote_cpu[k+1];
						vote_bus[k] = vote_bus[k+1];
						vote_tag[k] = vote_tag[k+1];
					end
				end
				if (hit)
					vote_count--;
				else
					r.status = cvt_pkg::ST_NOT_FOUND;
			end
			default: ;
		endcase
		best = 0;
		best_sum = -1;
		for (k = 0; k < vote_count; k++) begin
			s = int'(vote_cpu[k]) + int'(vote_bus[k]);
			if (s > best_sum) begin
				best_sum = s;
				best = k;
			end
		end
		c = '0;
		b = '0;
		if (best_sum > 0) begin
			c = vote_cpu[best];
			b = vote_bus[best];
		end
		if (c < floor_cpu_r) c = floor_cpu_r;
		if (c > cvt_pkg::CPU_CAP) c = cvt_pkg::CPU_CAP;
		if (b < floor_bus_r) b = floor_bus_r;
		if (b > cvt_pkg::BUS_CAP) b = cvt_pkg::BUS_CAP;
		r.cpu_clock = c;
		r.bus_clock = b;
		r.clock_change = (c != last_cpu) || (b != last_bus);
		last_cpu = c;
		last_bus = b;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic push_op(cvt_pkg::opcode_t op, int cpu, int bus, int id);
		cvt_pkg::in_word_t w;
		int                k;
		w.opcode = op;
		w.cpu_request = cpu[cvt_pkg::CPU_W-1:0];
		w.bus_request = bus[cvt_pkg::BUS_W-1:0];
		w.leave_id = id[cvt_pkg::ID_W-1:0];
		op_pending_q.push_back(w);
		pushed_cnt++;
		if ((op == cvt_pkg::OP_ENTER || op == cvt_pkg::OP_ENTER_HOT) && gen_count < DEPTH) begin
			for (k = 0; k < 16 && gen_live[k]; k++);
			gen_live[k] = 1'b1;
			gen_count++;
		end else if (op == cvt_pkg::OP_LEAVE && gen_live[w.leave_id]) begin
			gen_live[w.leave_id] = 1'b0;
			gen_count--;
		end
	endtask

	task automatic wait_idle();
		while (taken_cnt != pushed_cnt || winner_due_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic put_reg(logic [cvt_pkg::CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[cvt_pkg::CFG_DATA_W-1:0];
	endtask

	task automatic set_votes_cfg(int fc, int fb, int hc, int hb);
		wait_idle();
		put_reg(cvt_pkg::CFG_FLOOR_CPU, fc);
		put_reg(cvt_pkg::CFG_FLOOR_BUS, fb);
		put_reg(cvt_pkg::CFG_HOT_CPU, hc);
		put_reg(cvt_pkg::CFG_HOT_BUS, hb);
		@(posedge clk);
		cfg_we <= 1'b0;
		floor_cpu_r = fc[cvt_pkg::CPU_W-1:0];
		floor_bus_r = fb[cvt_pkg::BUS_W-1:0];
		hot_cpu_r = hc[cvt_pkg::CPU_W-1:0];
		hot_bus_r = hb[cvt_pkg::BUS_W-1:0];
	endtask

	function automatic int pick_cpu();
		case ($urandom_range(7))
			0: return 0;
			1: return 511;
			2: return 333;
			3: return 334;
			4: return $urandom_range(20);
			5: return $urandom_range(1, 2) * 100;
			default: return $urandom_range(511);
		endcase
	endfunction

	function automatic int pick_bus();
		case ($urandom_range(7))
			0: return 0;
			1: return 255;
			2: return 166;
			3: return 167;
			4: return $urandom_range(20);
			5: return $urandom_range(0, 1) * 100 + 50;
			default: return $urandom_range(255);
		endcase
	endfunction

	// fill and drain the table in turns so that both full and empty states recur
	task automatic random_votes(int n);
		int               i;
		int               r;
		int               id;
		cvt_pkg::opcode_t op;
		for (i = 0; i < n; i++) begin
			if (gen_count >= DEPTH) gen_filling = 1'b0;
			if (gen_count == 0) gen_filling = 1'b1;
			r = $urandom_range(99);
			if (gen_filling)
				op = (r < 55) ? cvt_pkg::OP_ENTER : (r < 70) ? cvt_pkg::OP_ENTER_HOT :
					(r < 85) ? cvt_pkg::OP_LEAVE : cvt_pkg::OP_RECOMPUTE;
			else
				op = (r < 15) ? cvt_pkg::OP_ENTER : (r < 22) ? cvt_pkg::OP_ENTER_HOT :
					(r < 88) ? cvt_pkg::OP_LEAVE : cvt_pkg::OP_RECOMPUTE;
			id = $urandom_range(15);
			if (op == cvt_pkg::OP_LEAVE && gen_count > 0 && $urandom_range(99) < 85)
				while (!gen_live[id])
					id = $urandom_range(15);
			push_op(op, pick_cpu(), pick_bus(), id);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// word source
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (op_pending_q.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= op_pending_q.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result sink, with one long hold-off to back the core up
	int  hold_left;
	bit  hold_done;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (!hold_done && rx_words >= 60) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= calm || $urandom_range(99) >= 20;
		end
	end

	always @(posedge clk) begin
		cvt_pkg::out_word_t got;
		cvt_pkg::out_word_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				winner_due_q.push_back(predict_vote(in_ch.data));
				taken_cnt++;
			end
			if (out_ch.valid && out_ch.ready) begin
				rx_words++;
				got = out_ch.data;
				if (winner_due_q.size() == 0) begin
					report_mismatch($sformatf("result word with nothing pending: %p", got));
				end else begin
					want = winner_due_q.pop_front();
					if (got.status !== want.status)
						report_mismatch($sformatf("status %0d, model %0d",
							got.status, want.status));
					if (got.assigned_id !== want.assigned_id)
						report_mismatch($sformatf("assigned_id %0d, model %0d",
							got.assigned_id, want.assigned_id));
					if (got.cpu_clock !== want.cpu_clock)
						report_mismatch($sformatf("cpu_clock %0d, model %0d",
							got.cpu_clock, want.cpu_clock));
					if (got.bus_clock !== want.bus_clock)
						report_mismatch($sformatf("bus_clock %0d, model %0d",
							got.bus_clock, want.bus_clock));
					if (got.clock_change !== want.clock_change)
						report_mismatch($sformatf("clock_change %0d, model %0d",
							got.clock_change, want.clock_change));
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		vote_count = 0;
		last_cpu = '0;
		last_bus = '0;
		floor_cpu_r = '0;
		floor_bus_r = '0;
		hot_cpu_r = '0;
		hot_bus_r = '0;
		gen_live = '0;
		gen_count = 0;
		gen_filling = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, zero sum, caps, ties, compaction, id reuse, full table
		set_votes_cfg(0, 0, 100, 50);
		push_op(cvt_pkg::OP_RECOMPUTE, 0, 0, 0);
		push_op(cvt_pkg::OP_LEAVE, 0, 0, 0);
		push_op(cvt_pkg::OP_ENTER, 0, 0, 0);
		push_op(cvt_pkg::OP_ENTER, 511, 255, 15);
		push_op(cvt_pkg::OP_ENTER_HOT, 0, 0, 0);
		push_op(cvt_pkg::OP_ENTER, 511, 255, 0);
		push_op(cvt_pkg::OP_LEAVE, 0, 0, 1);
		push_op(cvt_pkg::OP_LEAVE, 0, 0, 0);
		push_op(cvt_pkg::OP_ENTER, 200, 50, 0);
		push_op(cvt_pkg::OP_LEAVE, 0, 0, 15);
		for (k = 0; k < 13; k++)
			push_op(cvt_pkg::OP_ENTER, 100 + k, 150 - k, k);
		push_op(cvt_pkg::OP_ENTER, 1, 1, 0);
		push_op(cvt_pkg::OP_ENTER_HOT, 0, 0, 0);
		push_op(cvt_pkg::OP_LEAVE, 0, 0, 5);
		push_op(cvt_pkg::OP_ENTER, 300, 160, 0);

		set_votes_cfg(333, 166, 333, 166);
		random_votes(90);
		set_votes_cfg(511, 255, 0, 0);
		random_votes(90);
		set_votes_cfg($urandom_range(333), $urandom_range(166),
			$urandom_range(511), $urandom_range(255));
		random_votes(110);
		set_votes_cfg(0, 0, $urandom_range(333), $urandom_range(166));
		random_votes(110);

		while (taken_cnt != pushed_cnt || winner_due_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (winner_due_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", winner_due_q.size()));
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
